// File: rtl/assert_macros.svh
// Assertion macros shared by the queue, back end and top level of the divider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, switched off while reset is held.
`define SDRM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define SDRM_NEVER(lbl, clk, rst_n, cond, msg) \
    `SDRM_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// File: rtl/sdrm_pkg.sv
// Types and constants for the signed divider with rounding kinds.
package sdrm_pkg;

    // Operand width
    localparam int WIDTH = 32;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Cycles from an accepted command to its result strobe being sampled
    localparam int LATENCY = WIDTH + 4;

    typedef logic [WIDTH-1:0] t_word;
    typedef logic [WIDTH:0]   t_wide;

    // Rounding kinds (code 3 behaves as toward zero)
    localparam logic [1:0] KIND_TRUNC = 2'd0;
    localparam logic [1:0] KIND_FLOOR = 2'd1;
    localparam logic [1:0] KIND_CEIL  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [WIDTH-1:0] dividend;
        logic signed [WIDTH-1:0] divisor;
    } t_cmd;

    typedef struct packed {
        logic signed [WIDTH-1:0] quotient;
        logic signed [WIDTH-1:0] remainder;
        logic [1:0]              status;
    } t_res;

    // Side information carried alongside the magnitudes
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] kind;
        logic       xneg;
        logic       neg;
        t_word      y;
    } t_meta;

    // Classified item handed from front to back
    typedef struct packed {
        t_meta meta;
        t_word ax;
        t_word ay;
    } t_task;

    // Queue to back-end handshake
    typedef struct packed {
        logic valid;
    } t_qctl;

endpackage

// File: rtl/sdrm_front.sv
// Front end: classifies a command and forms operand magnitudes.
module sdrm_front (
    input  sdrm_pkg::t_cmd  i_cmd,
    output sdrm_pkg::t_task o_task
);

    sdrm_pkg::t_word x;
    sdrm_pkg::t_word y;
    logic            xneg;
    logic            yneg;

    assign x    = sdrm_pkg::t_word'(i_cmd.dividend);
    assign y    = sdrm_pkg::t_word'(i_cmd.divisor);
    assign xneg = x[sdrm_pkg::WIDTH-1];
    assign yneg = y[sdrm_pkg::WIDTH-1];

    // Special cases and magnitudes
    always_comb begin
        o_task.meta.kind = i_cmd.kind;
        o_task.meta.xneg = xneg;
        o_task.meta.neg  = xneg ^ yneg;
        o_task.meta.y    = y;
        if (y == '0) begin
            o_task.meta.status = sdrm_pkg::ST_DIV0;
        end else if ((x == {1'b1, {(sdrm_pkg::WIDTH-1){1'b0}}}) && (y == '1)) begin
            o_task.meta.status = sdrm_pkg::ST_OVF;
        end else begin
            o_task.meta.status = sdrm_pkg::ST_OK;
        end
        o_task.ax = xneg ? (~x + sdrm_pkg::t_word'(1)) : x;
        o_task.ay = yneg ? (~y + sdrm_pkg::t_word'(1)) : y;
    end

endmodule

// File: rtl/sdrm_queue.sv
// Short queue decoupling the front end from the division pipeline.
`include "assert_macros.svh"

module sdrm_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sdrm_pkg::t_task      i_task,
    input  logic                 i_pop,
    output sdrm_pkg::t_qctl      o_ctl,
    output sdrm_pkg::t_task      o_task,
    output logic                 o_full
);

    sdrm_pkg::t_task               r_mem [sdrm_pkg::QDEPTH];
    logic [sdrm_pkg::QAW-1:0]      r_wr;
    logic [sdrm_pkg::QAW-1:0]      r_rd;
    logic [sdrm_pkg::QCW-1:0]      r_count;
    logic [sdrm_pkg::QAW-1:0]      n_wr;
    logic [sdrm_pkg::QAW-1:0]      n_rd;
    logic [sdrm_pkg::QCW-1:0]      n_count;
    logic                          push_ok;
    logic                          pop_ok;

    assign o_full      = (r_count == sdrm_pkg::QCW'(sdrm_pkg::QDEPTH));
    assign o_ctl.valid = (r_count != '0);
    assign o_task      = r_mem[r_rd];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_pop && o_ctl.valid;

    // Pointer and fill count update
    always_comb begin
        n_wr    = push_ok ? r_wr + 1'b1 : r_wr;
        n_rd    = pop_ok ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!push_ok && pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_task;
        end
    end

    `SDRM_NEVER(a_count_bound, i_clk, i_rst_n, r_count > sdrm_pkg::QCW'(sdrm_pkg::QDEPTH), "queue count beyond depth")
    `SDRM_ASSERT(a_count_track, i_clk, i_rst_n, (push_ok && !pop_ok) |=> (r_count == $past(r_count) + 1'b1), "queue count missed a push")

endmodule

// File: rtl/sdrm_back.sv
// Back end: pipelined restoring divider plus rounding and remainder fix-up.
`include "assert_macros.svh"

module sdrm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sdrm_pkg::t_qctl i_ctl,
    input  sdrm_pkg::t_task i_task,
    output logic            o_pop,
    output logic            o_valid,
    output sdrm_pkg::t_res  o_res
);

    localparam int W = sdrm_pkg::WIDTH;

    // Divider stages: index 0 is loaded from the queue, index W holds qm and rm
    logic            r_v   [W+1];
    sdrm_pkg::t_word r_rem [W+1];
    sdrm_pkg::t_word r_dvd [W+1];
    sdrm_pkg::t_word r_dsr [W+1];
    sdrm_pkg::t_meta r_meta[W+1];
    logic            n_v   [W+1];
    sdrm_pkg::t_word n_rem [W+1];
    sdrm_pkg::t_word n_dvd [W+1];

    // Fix-up stage
    logic            r_fv;
    sdrm_pkg::t_word r_q;
    sdrm_pkg::t_word r_r0;
    sdrm_pkg::t_word r_add;
    logic [1:0]      r_fst;
    logic            n_fv;
    sdrm_pkg::t_word n_q;
    sdrm_pkg::t_word n_r0;
    sdrm_pkg::t_word n_add;
    logic            adj;

    // Output register
    logic            r_ov;
    sdrm_pkg::t_res  r_res;
    sdrm_pkg::t_res  n_res;

    sdrm_pkg::t_wide trial [W];

    // The pipeline never stalls, so take an item whenever one waits
    assign o_pop = i_ctl.valid;

    // One quotient bit per stage
    always_comb begin
        n_v[0]   = i_ctl.valid;
        n_rem[0] = '0;
        n_dvd[0] = i_task.ax;
        for (int s = 0; s < W; s++) begin
            trial[s] = {r_rem[s], r_dvd[s][W-1]} - {1'b0, r_dsr[s]};
            n_v[s+1] = r_v[s];
            if (!trial[s][W]) begin
                n_rem[s+1] = trial[s][W-1:0];
                n_dvd[s+1] = {r_dvd[s][W-2:0], 1'b1};
            end else begin
                n_rem[s+1] = {r_rem[s][W-2:0], r_dvd[s][W-1]};
                n_dvd[s+1] = {r_dvd[s][W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= W; s++) begin
                r_v[s] <= 1'b0;
            end
        end else begin
            for (int s = 0; s <= W; s++) begin
                r_v[s] <= n_v[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_rem[0];
        r_dvd[0]  <= n_dvd[0];
        r_dsr[0]  <= i_task.ay;
        r_meta[0] <= i_task.meta;
        for (int s = 0; s < W; s++) begin
            r_rem[s+1]  <= n_rem[s+1];
            r_dvd[s+1]  <= n_dvd[s+1];
            r_dsr[s+1]  <= r_dsr[s];
            r_meta[s+1] <= r_meta[s];
        end
    end

    // Rounding: floor of a negative or ceiling of a positive inexact quotient
    // moves one step away from zero; the remainder moves by the divisor.
    always_comb begin
        adj = (r_rem[W] != '0)
            && (((r_meta[W].kind == sdrm_pkg::KIND_FLOOR) && r_meta[W].neg)
             || ((r_meta[W].kind == sdrm_pkg::KIND_CEIL) && !r_meta[W].neg));
        n_fv = r_v[W];
        if (r_meta[W].neg) begin
            n_q = adj ? ~r_dvd[W] : (~r_dvd[W] + sdrm_pkg::t_word'(1));
        end else begin
            n_q = adj ? (r_dvd[W] + sdrm_pkg::t_word'(1)) : r_dvd[W];
        end
        n_r0 = r_meta[W].xneg ? (~r_rem[W] + sdrm_pkg::t_word'(1)) : r_rem[W];
        if (!adj) begin
            n_add = '0;
        end else if (r_meta[W].neg) begin
            n_add = r_meta[W].y;
        end else begin
            n_add = ~r_meta[W].y + sdrm_pkg::t_word'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_r0  <= n_r0;
        r_add <= n_add;
        r_fst <= r_meta[W].status;
    end

    // Final result with the remainder fix-up added, errors forced to zero
    always_comb begin
        n_res.status = r_fst;
        if (r_fst != sdrm_pkg::ST_OK) begin
            n_res.quotient  = '0;
            n_res.remainder = '0;
        end else begin
            n_res.quotient  = r_q;
            n_res.remainder = r_r0 + r_add;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

    `SDRM_ASSERT(a_err_zero, i_clk, i_rst_n, (o_valid && (o_res.status != sdrm_pkg::ST_OK)) |-> ((o_res.quotient == '0) && (o_res.remainder == '0)), "error result not zeroed")

endmodule

// File: rtl/signed_divider_rounding_modes.sv
// Top level of the signed divider with truncating, floor and ceiling rounding.
// One command may be started every clock cycle while busy is low. Each result
// appears on o_res with o_valid high for one cycle; the command passes through
// the queue, the divider pipeline, which resolves one quotient bit per stage,
// a rounding stage and an output register. Results come out in command order
// and cannot be held off by the receiver, so the pipeline never stalls and the
// four-entry queue behind the front end drains every cycle; busy rises only
// when that queue is full. A zero divisor or the most negative dividend over
// minus one returns a status code with zero quotient and remainder.
`include "assert_macros.svh"

module signed_divider_rounding_modes (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  sdrm_pkg::t_cmd i_cmd,
    output logic           busy,
    output logic           o_valid,
    output sdrm_pkg::t_res o_res
);

    sdrm_pkg::t_task front_task;
    sdrm_pkg::t_task queue_task;
    sdrm_pkg::t_qctl queue_ctl;
    logic            pop;
    logic            full;
    logic            xfer;

    assign busy = full;
    assign xfer = start && !full;

    sdrm_front u_front (
        .i_cmd  (i_cmd),
        .o_task (front_task)
    );

    sdrm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (xfer),
        .i_task  (front_task),
        .i_pop   (pop),
        .o_ctl   (queue_ctl),
        .o_task  (queue_task),
        .o_full  (full)
    );

    sdrm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (queue_ctl),
        .i_task  (queue_task),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    `SDRM_ASSERT(a_latency, i_clk, i_rst_n, xfer |-> ##(sdrm_pkg::LATENCY) o_valid, "result missing after fixed latency")

endmodule
